// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Each macro expands to one labeled concurrent assertion with async reset gating.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define MST_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/mst_pkg.sv =====
// Package for the multi-byte separator tokenizer: result kinds, register map, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

    localparam int MAX_SEP_DEF = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 64;
    localparam int SEP_BYTES_W = 64;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_LIST_END = 2'd2
    } kind_t;

    // register index, taken from paddr[3]
    localparam logic REG_SEP_LENGTH = 1'b0;
    localparam logic REG_SEP_BYTES  = 1'b1;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } out_req_t;

endpackage

`default_nettype wire

// ===== rtl/mst_cfg.sv =====
// APB register file for the tokenizer: separator length and separator bytes.
// Depends on mst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mst_cfg #(
    parameter int MAX_SEP = 8,
    parameter int LW      = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mst_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mst_pkg::DATA_W-1:0] pwdata,
    output logic      [mst_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output logic      [LW-1:0]              len_eff,
    output logic      [8*MAX_SEP-1:0]       sep_pat,
    output logic                            len_wr
);
    import mst_pkg::*;

    localparam int SB = (MAX_SEP < 8) ? MAX_SEP : 8;

    logic [3:0]             sep_length_reg;
    logic [SEP_BYTES_W-1:0] sep_bytes_reg;
    logic                   wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign len_wr = wr && (paddr[3] == REG_SEP_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_length_reg <= 4'd1;
            sep_bytes_reg  <= SEP_BYTES_W'(32);
        end
        else if (wr)
        begin
            if (paddr[3] == REG_SEP_LENGTH)
                sep_length_reg <= pwdata[3:0];
            else
                sep_bytes_reg <= pwdata[SEP_BYTES_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_SEP_LENGTH)
            prdata = {{(DATA_W-4){1'b0}}, sep_length_reg};
        else
            prdata = sep_bytes_reg;
    end

    always_comb
    begin
        if (sep_length_reg == 4'd0)
            len_eff = LW'(1);
        else if (int'(sep_length_reg) > MAX_SEP)
            len_eff = LW'(MAX_SEP);
        else
            len_eff = LW'(sep_length_reg);
    end

    // bytes past the eighth compare as zero
    always_comb
    begin
        sep_pat            = '0;
        sep_pat[8*SB-1:0]  = sep_bytes_reg[8*SB-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/mst_core.sv =====
// Tokenizer core: separator window, parallel compare, word state and end-of-string flush.
// Depends on mst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mst_core #(
    parameter int MAX_SEP = 8,
    parameter int LW      = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           char_in,
    input  wire logic                 char_present,
    input  wire logic                 end_of_string,
    input  wire logic [LW-1:0]        len_eff,
    input  wire logic [8*MAX_SEP-1:0] sep_pat,
    input  wire logic                 len_wr,
    input  wire logic                 room,
    output mst_pkg::out_req_t         req
);
    import mst_pkg::*;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'b01,
        MODE_FLUSH = 2'b10
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  win_reg  [MAX_SEP];
    logic [7:0]  win_next [MAX_SEP];
    logic [7:0]  win_wr   [MAX_SEP];
    logic [7:0]  win_sh   [MAX_SEP];
    logic [LW-1:0] fill_reg, fill_next;
    logic          open_reg, open_next;
    logic [LW-1:0] f;
    logic [LW-1:0] f_inc;
    logic          accept;
    logic          match;

    assign in_ready = (mode_reg == MODE_RUN) && room;
    assign accept   = in_valid && in_ready;
    assign f        = (fill_reg >= len_eff) ? len_eff - 1'b1 : fill_reg;
    assign f_inc    = f + 1'b1;

    always_comb
    begin
        for (int i = 0; i < MAX_SEP; i++)
            win_wr[i] = (accept && char_present && LW'(i) == f) ? char_in : win_reg[i];
        for (int i = 0; i < MAX_SEP - 1; i++)
            win_sh[i] = win_wr[i+1];
        win_sh[MAX_SEP-1] = win_wr[MAX_SEP-1];
        match = 1'b1;
        for (int i = 0; i < MAX_SEP; i++)
            if (LW'(i) < len_eff && win_wr[i] != sep_pat[8*i +: 8])
                match = 1'b0;
    end

    always_comb
    begin
        mode_next = mode_reg;
        win_next  = win_reg;
        fill_next = fill_reg;
        open_next = open_reg;
        req       = '0;
        if (len_wr)
        begin
            fill_next = '0;
        end
        else if (mode_reg == MODE_FLUSH)
        begin
            if (room)
            begin
                req.push = 1'b1;
                if (fill_reg != '0)
                begin
                    req.res.kind = KIND_BYTE;
                    req.res.ch   = win_reg[0];
                    win_next     = win_sh;
                    fill_next    = fill_reg - 1'b1;
                    open_next    = 1'b1;
                end
                else if (open_reg)
                begin
                    req.res.kind = KIND_WORD_END;
                    open_next    = 1'b0;
                end
                else
                begin
                    req.res.kind = KIND_LIST_END;
                    mode_next    = MODE_RUN;
                end
            end
        end
        else if (accept)
        begin
            fill_next = f;
            if (char_present)
            begin
                win_next  = win_wr;
                fill_next = f_inc;
                if (f_inc == len_eff)
                begin
                    if (match)
                    begin
                        fill_next = '0;
                        if (open_reg)
                        begin
                            req.push     = 1'b1;
                            req.res.kind = KIND_WORD_END;
                        end
                        open_next = 1'b0;
                    end
                    else
                    begin
                        req.push     = 1'b1;
                        req.res.kind = KIND_BYTE;
                        req.res.ch   = win_wr[0];
                        win_next     = win_sh;
                        fill_next    = f;
                        open_next    = 1'b1;
                    end
                end
            end
            if (end_of_string)
                mode_next = MODE_FLUSH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RUN;
            fill_reg <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `MST_ASSERT(a_fill_below_len, clk, rst_n, fill_reg < len_eff, "window fill reached separator length")
    `MST_ASSERT(a_push_has_room, clk, rst_n, req.push |-> room, "result pushed into a full queue")
    `MST_ASSERT(a_flush_done_clean, clk, rst_n, (mode_reg == MODE_RUN && $past(mode_reg) == MODE_FLUSH) |-> (fill_reg == '0 && !open_reg), "flush ended with data left")

endmodule

`default_nettype wire

// ===== rtl/mst_outq.sv =====
// Two-entry result queue (output register plus skid register) toward the master stream.
// Depends on mst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mst_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mst_pkg::out_req_t req,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mst_pkg::result_t       out_res
);
    import mst_pkg::*;

    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = count_reg != 2'd0;
    assign room      = count_reg != 2'd2;
    assign pop       = out_valid && out_ready;
    assign out_res   = head_reg;

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        if (req.push && !pop)
        begin
            if (count_reg == 2'd0)
                head_next = req.res;
            else
                skid_next = req.res;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !req.push)
        begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && req.push)
        begin
            if (count_reg == 2'd1)
                head_next = req.res;
            else
            begin
                head_next = skid_reg;
                skid_next = req.res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    `MST_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3, "queue count out of range")
    `MST_NEVER(a_no_push_full, clk, rst_n, req.push && count_reg == 2'd2, "push into full queue")
    `MST_ASSERT(a_skid_moves_up, clk, rst_n, (count_reg == 2'd2 && pop && !req.push) |=> head_reg == $past(skid_reg), "skid entry lost on pop")

endmodule

`default_nettype wire

// ===== rtl/multibyte_separator_tokenizer.sv =====
// Results are registered in a two-entry output queue that decouples m_tready, then show
// on the master side. Throughput: one input request per cycle when the queue has room and
// no flush runs; each request gives at most one result at once. A string's final item adds
// a flush (window bytes, word end, list end) during which s_tready is low.
// Reset (rst_n low, async): window empty, no word open, sep_length 1, sep_bytes 0x20.
`timescale 1ns / 1ps
`default_nettype none

module multibyte_separator_tokenizer #(
    parameter int MAX_SEP = mst_pkg::MAX_SEP_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,    // [7:0] char_in
    input  wire logic [0:0]                 s_tuser,    // [0] char_present
    input  wire logic                       s_tlast,    // end_of_string
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,    // [7:0] char_out
    output logic      [1:0]                 m_tuser,    // [1:0] item_kind
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mst_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mst_pkg::DATA_W-1:0] pwdata,
    output logic      [mst_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import mst_pkg::*;

    localparam int LW = $clog2(MAX_SEP + 1);

    logic [LW-1:0]        len_eff;
    logic [8*MAX_SEP-1:0] sep_pat;
    logic                 len_wr;
    logic                 room;
    out_req_t             req;
    result_t              out_res;

    mst_cfg #(
        .MAX_SEP (MAX_SEP),
        .LW      (LW)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .len_eff (len_eff),
        .sep_pat (sep_pat),
        .len_wr  (len_wr)
    );

    mst_core #(
        .MAX_SEP (MAX_SEP),
        .LW      (LW)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .char_in       (s_tdata),
        .char_present  (s_tuser[0]),
        .end_of_string (s_tlast),
        .len_eff       (len_eff),
        .sep_pat       (sep_pat),
        .len_wr        (len_wr),
        .room          (room),
        .req           (req)
    );

    mst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.ch;
    assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== test/tb_multibyte_separator_tokenizer.sv =====
// Self-checking testbench for multibyte_separator_tokenizer: stream bytes in, words out.
// A scoreboard class predicts word bytes, word ends and list ends; needs mst_pkg and the RTL.
`timescale 1ns / 1ps

module tb_multibyte_separator_tokenizer;

    import mst_pkg::*;

    localparam int WIN = MAX_SEP_DEF;

    class word_split_scoreboard;
        logic [3:0]  sep_len_reg;
        logic [63:0] sep_reg;
        logic [7:0]  window[WIN];
        int unsigned fill;
        bit          word_open;
        result_t     expected[$];
        int          faults;

        function new();
            sep_len_reg = 4'd1;
            sep_reg     = 64'h20;
            fill        = 0;
            word_open   = 1'b0;
            faults      = 0;
        endfunction

        function void write_reg(logic sel, logic [63:0] value);
            if (sel == REG_SEP_LENGTH)
            begin
                sep_len_reg = value[3:0];
                fill = 0;
            end
            else
                sep_reg = value;
        endfunction

        function int unsigned span();
            if (sep_len_reg == 4'd0)
                return 1;
            if (sep_len_reg > WIN)
                return WIN;
            return sep_len_reg;
        endfunction

        function void add(kind_t kind, logic [7:0] ch);
            result_t r;
            r.kind = kind;
            r.ch   = ch;
            expected.push_back(r);
        endfunction

        // oldest window byte leaves as a word byte
        function void shift_out();
            add(KIND_BYTE, window[0]);
            for (int i = 1; i < fill; i++)
                window[i - 1] = window[i];
            fill--;
            word_open = 1'b1;
        endfunction

        function void close_word();
            if (word_open)
                add(KIND_WORD_END, 8'h00);
            word_open = 1'b0;
        endfunction

        function void take_char(logic [7:0] ch, bit present, bit last);
            int unsigned len;
            bit hit;
            len = span();
            if (fill >= len)
                fill = len - 1;
            if (present)
            begin
                window[fill] = ch;
                fill++;
                if (fill == len)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (window[i] !== sep_reg[8*i +: 8])
                            hit = 1'b0;
                    if (hit)
                    begin
                        fill = 0;
                        close_word();
                    end
                    else
                        shift_out();
                end
            end
            if (last)
            begin
                while (fill > 0)
                    shift_out();
                close_word();
                add(KIND_LIST_END, 8'h00);
            end
        endfunction

        function void check_token(logic [1:0] kind, logic [7:0] ch);
            result_t want;
            if (expected.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: kind %0d char %02h", kind, ch);
                return;
            end
            want = expected.pop_front();
            if (kind !== want.kind || ch !== want.ch)
            begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected kind %0d char %02h, got kind %0d char %02h",
                             want.kind, want.ch, kind, ch);
            end
        endfunction

        function void finish();
            if (expected.size() != 0)
            begin
                $display("%0d expected results never arrived", expected.size());
                faults += expected.size();
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    word_split_scoreboard tokens = new();
    bit long_hold = 1'b0;
    int burst_left = 0;

    multibyte_separator_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_multibyte_separator_tokenizer failed");
        $finish;
    end

    // receiver: checks results, stalls in changing modes, honors a long hold
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tokens.check_token(m_tuser, m_tdata);
            if (long_hold)
            begin
                long_hold = 1'b0;
                hold_left = 300;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= !m_tready;
                endcase
        end
    end

    task automatic send(logic [7:0] ch, bit present, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tokens.take_char(ch, present, last);
        burst_left--;
    endtask

    task automatic apb_write(logic sel, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tokens.write_reg(sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // all results in, then room for a flush still running inside the block
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens.expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0]  str[$];
        logic [7:0]  base;
        logic [63:0] sep_val;
        int unsigned len_val;
        int phase;
        int phase_items;
        int n_elem;
        int choice;
        int k;
        int j;
        int pick;
        int waited;
        bit last_present;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string, then reset separator with leading, doubled and final spaces
        send(8'h00, 1'b0, 1'b1);
        send(8'h20, 1'b1, 1'b0);
        send(8'h41, 1'b1, 1'b0);
        send(8'h20, 1'b1, 1'b0);
        send(8'h20, 1'b1, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b0);
        send(8'h5A, 1'b0, 1'b0);
        send(8'h20, 1'b1, 1'b1);
        wait_idle();

        // three-byte separator, length changed mid-string with a word open
        apb_write(REG_SEP_BYTES, 64'h636261);
        apb_write(REG_SEP_LENGTH, 64'd3);
        send(8'h78, 1'b1, 1'b0);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b0);
        send(8'h79, 1'b1, 1'b0);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        wait_idle();
        apb_write(REG_SEP_LENGTH, 64'd2);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h7A, 1'b1, 1'b1);
        wait_idle();

        // zero length acts as one
        apb_write(REG_SEP_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(REG_SEP_LENGTH, 64'd0);
        send(8'hFF, 1'b1, 1'b0);
        send(8'h00, 1'b1, 1'b1);
        wait_idle();

        // oversize length clamps to the window, final item flushes it
        apb_write(REG_SEP_BYTES, 64'h0);
        apb_write(REG_SEP_LENGTH, 64'd15);
        send(8'h00, 1'b1, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b1);

        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            base = 8'($urandom_range(0, 255));
            for (k = 0; k < 8; k++)
                sep_val[8*k +: 8] = $urandom_range(0, 1) ? base : 8'($urandom_range(0, 255));
            len_val = (phase == 0) ? 1 : (phase == 1) ? 8 : $urandom_range(1, 8);
            apb_write(REG_SEP_BYTES, sep_val);
            apb_write(REG_SEP_LENGTH, 64'(len_val));
            if (phase == 3)
                long_hold = 1'b1;
            phase_items = 0;
            while (phase_items < 8)
            begin
                str.delete();
                n_elem = $urandom_range(0, 10);
                for (k = 0; k < n_elem; k++)
                begin
                    choice = $urandom_range(0, 99);
                    if (choice < 25)
                    begin
                        for (j = 0; j < len_val; j++)
                            str.push_back(sep_val[8*j +: 8]);
                    end
                    else if (choice < 60)
                    begin
                        pick = $urandom_range(0, len_val - 1);
                        str.push_back(sep_val[8*pick +: 8]);
                    end
                    else
                        str.push_back(8'($urandom_range(0, 255)));
                end
                last_present = (str.size() != 0) && ($urandom_range(0, 1) == 1);
                for (k = 0; k < str.size(); k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    send(str[k], 1'b1, last_present && (k == str.size() - 1));
                    phase_items++;
                end
                if (!last_present)
                begin
                    send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    phase_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (tokens.expected.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        tokens.finish();
        if (tokens.faults == 0)
            $display("tb_multibyte_separator_tokenizer passed");
        else
            $display("tb_multibyte_separator_tokenizer failed");
        $finish;
    end

endmodule
